// ===== design/hufd_pkg.sv =====
// Shared constants, types and UTF-8 check for the Huffman UTF-8 stream decoder.
package hufd_pkg;

    localparam int TREE_NODES = 1024;
    localparam int TREE_DEPTH = 64;
    localparam int FULL_CHUNK = 4096;

    localparam int NODE_AW  = $clog2(TREE_NODES);
    localparam int STACK_AW = $clog2(TREE_DEPTH);
    localparam int ENTRY_W  = 35;
    localparam int CNT_W    = NODE_AW + 1;
    localparam int SCNT_W   = STACK_AW + 1;
    localparam int CHUNK_W  = 13;

    localparam logic [31:0] PFX_2B = 32'h0000_C000;
    localparam logic [31:0] PFX_3B = 32'h00E0_0000;
    localparam logic [31:0] PFX_4B = 32'hF000_0000;
    localparam logic [7:0]  MAX_LEAD = 8'd244;
    localparam logic [7:0]  MAX_CONT = 8'd144;

    typedef enum logic [6:0] {
        PH_TREE  = 7'b0000001,
        PH_CSIZE = 7'b0000010,
        PH_CBITS = 7'b0000100,
        PH_CHDR  = 7'b0001000,
        PH_CCNT  = 7'b0010000,
        PH_SYM   = 7'b0100000,
        PH_STOP  = 7'b1000000
    } t_phase;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b00000001,
        ST_BIT   = 8'b00000010,
        ST_POP   = 8'b00000100,
        ST_LOOK  = 8'b00001000,
        ST_EMIT  = 8'b00010000,
        ST_END   = 8'b00100000,
        ST_STAT  = 8'b01000000,
        ST_FLUSH = 8'b10000000
    } t_state;

    function automatic logic is_cont(input logic [7:0] c);
        is_cont = (c[7:6] == 2'b10);
    endfunction

    function automatic logic char_ok(input logic [31:0] v, input logic [3:0] size);
        logic [7:0] c1, c2, c3, c4;
        c1 = v[31:24];
        c2 = v[23:16];
        c3 = v[15:8];
        c4 = v[7:0];
        case (size)
            4'd1: char_ok = (v[31:7] == 25'd0);
            4'd2: char_ok = (v[31:16] == 16'd0) && (c3[7:5] == 3'b110) && is_cont(c4);
            4'd3: char_ok = (c1 == 8'd0) && (c2[7:4] == 4'b1110) && is_cont(c3)
                            && is_cont(c4);
            default: char_ok = (c1[7:3] == 5'b11110) && is_cont(c2) && is_cont(c3)
                               && is_cont(c4) && !(c1 > MAX_LEAD)
                               && !(c1 == MAX_LEAD && c2 >= MAX_CONT);
        endcase
    endfunction

endpackage

// ===== design/huffman_utf8_stream_decoder.sv =====
// Top level of the Huffman UTF-8 stream decoder.
//
// Channel | Dir | Fields
// s_axis  | in  | tdata: in_byte[7:0]; tlast: in_last
// m_axis  | out | tdata: out_byte[7:0]; tlast: out_last; tuser: out_done, out_error
//
// A word with a free output passes through these states: idle accepts it, the bit state
// handles each code bit, a look state follows each symbol bit for the tree memory read
// and a pop state each finished leaf for the parse stack pop, an emit state sends each
// decoded byte, then come an end state, a status state once decoding stops, and a flush
// state. Decoded bytes pass through a hold register and an output register; a stalled
// output holds the bit walk. Reset is synchronous, active low, and returns the decoder
// to tree parsing. After done or error, words are still accepted and then dropped.
module huffman_utf8_stream_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // in_byte[7:0]
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // out_byte[7:0]
    output logic       m_axis_tlast,
    output logic [1:0] m_axis_tuser    // out_done, out_error
);

    localparam int AW  = hufd_pkg::NODE_AW;
    localparam int SAW = hufd_pkg::STACK_AW;
    localparam int EW  = hufd_pkg::ENTRY_W;
    localparam int CW  = hufd_pkg::CNT_W;
    localparam int SCW = hufd_pkg::SCNT_W;
    localparam int KW  = hufd_pkg::CHUNK_W;

    hufd_pkg::t_state r_state, n_state;
    hufd_pkg::t_phase r_phase, n_phase;

    logic [7:0]    r_byte, n_byte;
    logic          r_in_last, n_in_last;
    logic [2:0]    r_bit, n_bit;
    logic [31:0]   r_char, n_char;
    logic [4:0]    r_bits_left, n_bits_left;
    logic [3:0]    r_hdr, n_hdr;
    logic [CW-1:0] r_node_cnt, n_node_cnt;
    logic [SCW-1:0] r_stk_cnt, n_stk_cnt;
    logic [AW-1:0] r_cur, n_cur;
    logic [CW-1:0] r_cur_right, n_cur_right;
    logic [CW-1:0] r_root_right, n_root_right;
    logic [AW-1:0] r_next, n_next;
    logic [KW-1:0] r_chunk, n_chunk;
    logic          r_last_chunk, n_last_chunk;
    logic          r_err, n_err;
    logic [EW-1:0] r_emit, n_emit;
    logic [1:0]    r_emit_cnt, n_emit_cnt;

    logic          r_hold_v, n_hold_v;
    logic [7:0]    r_hold_byte, n_hold_byte;
    logic [1:0]    r_hold_user, n_hold_user;
    logic          r_out_v, n_out_v;
    logic [7:0]    r_out_byte, n_out_byte;
    logic          r_out_last, n_out_last;
    logic [1:0]    r_out_user, n_out_user;

    logic          tree_we;
    logic [AW-1:0] tree_waddr, tree_raddr;
    logic [EW-1:0] tree_wdata, tree_rdata;
    logic          stk_we;
    logic [SAW-1:0] stk_waddr, stk_raddr;
    logic [AW-1:0] stk_wdata, stk_rdata;

    logic          cur_bit, adv, out_free, put_ok;
    logic          put_en;
    logic [7:0]    put_byte;
    logic [1:0]    put_user;
    logic [4:0]    nb;
    logic [31:0]   nchar;
    logic [CW-1:0] sym_next;
    logic [KW-1:0] chunk_dec;
    logic [CW-1:0] node_dec;

    hufd_ram #(.WIDTH(EW), .DEPTH(hufd_pkg::TREE_NODES)) u_tree_ram (
        .i_clk   (i_clk),
        .i_we    (tree_we),
        .i_waddr (tree_waddr),
        .i_wdata (tree_wdata),
        .i_raddr (tree_raddr),
        .o_rdata (tree_rdata)
    );

    hufd_ram #(.WIDTH(AW), .DEPTH(hufd_pkg::TREE_DEPTH)) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    assign s_axis_tready = (r_state == hufd_pkg::ST_IDLE);
    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_user;

    assign cur_bit   = r_byte[r_bit];
    assign out_free  = !r_out_v || m_axis_tready;
    assign put_ok    = !r_hold_v || out_free;
    assign nb        = r_bits_left - 5'd1;
    assign nchar     = r_char | (32'(cur_bit) << nb);
    assign sym_next  = cur_bit ? r_cur_right : (CW'(r_cur) + CW'(1));
    assign chunk_dec = r_chunk - KW'(1);
    assign node_dec  = r_node_cnt - CW'(1);

    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_byte       = r_byte;
        n_in_last    = r_in_last;
        n_bit        = r_bit;
        n_char       = r_char;
        n_bits_left  = r_bits_left;
        n_hdr        = r_hdr;
        n_node_cnt   = r_node_cnt;
        n_stk_cnt    = r_stk_cnt;
        n_cur        = r_cur;
        n_cur_right  = r_cur_right;
        n_root_right = r_root_right;
        n_next       = r_next;
        n_chunk      = r_chunk;
        n_last_chunk = r_last_chunk;
        n_err        = r_err;
        n_emit       = r_emit;
        n_emit_cnt   = r_emit_cnt;
        n_hold_v     = r_hold_v;
        n_hold_byte  = r_hold_byte;
        n_hold_user  = r_hold_user;
        n_out_v      = r_out_v && !m_axis_tready;
        n_out_byte   = r_out_byte;
        n_out_last   = r_out_last;
        n_out_user   = r_out_user;
        tree_we      = 1'b0;
        tree_waddr   = r_node_cnt[AW-1:0];
        tree_wdata   = '0;
        tree_raddr   = r_next;
        stk_we       = 1'b0;
        stk_waddr    = r_stk_cnt[SAW-1:0];
        stk_wdata    = r_node_cnt[AW-1:0];
        stk_raddr    = SAW'(r_stk_cnt - SCW'(1));
        adv          = 1'b0;
        put_en       = 1'b0;
        put_byte     = '0;
        put_user     = '0;

        case (r_state)
            hufd_pkg::ST_IDLE: begin
                if (s_axis_tvalid && r_phase != hufd_pkg::PH_STOP) begin
                    n_byte    = s_axis_tdata;
                    n_in_last = s_axis_tlast;
                    n_bit     = 3'd7;
                    n_state   = hufd_pkg::ST_BIT;
                end
            end
            hufd_pkg::ST_BIT: begin
                adv = 1'b1;
                case (r_phase)
                    hufd_pkg::PH_TREE: begin
                        if (r_node_cnt >= CW'(hufd_pkg::TREE_NODES)) begin
                            n_err   = 1'b1;
                            n_phase = hufd_pkg::PH_STOP;
                        end else begin
                            n_node_cnt = r_node_cnt + CW'(1);
                            if (cur_bit) begin
                                n_char  = '0;
                                n_hdr   = '0;
                                n_phase = hufd_pkg::PH_CSIZE;
                            end else if (r_stk_cnt >= SCW'(hufd_pkg::TREE_DEPTH)) begin
                                n_err   = 1'b1;
                                n_phase = hufd_pkg::PH_STOP;
                            end else begin
                                tree_we   = 1'b1;
                                stk_we    = 1'b1;
                                n_stk_cnt = r_stk_cnt + SCW'(1);
                            end
                        end
                    end
                    hufd_pkg::PH_CSIZE: begin
                        case (r_hdr)
                            4'd0: begin
                                if (!cur_bit) begin
                                    n_hdr = 4'd1; n_char = '0; n_bits_left = 5'd7;
                                    n_phase = hufd_pkg::PH_CBITS;
                                end else begin
                                    n_hdr = 4'd1;
                                end
                            end
                            4'd1: begin
                                if (!cur_bit) begin
                                    n_err = 1'b1; n_phase = hufd_pkg::PH_STOP;
                                end else begin
                                    n_hdr = 4'd2;
                                end
                            end
                            4'd2: begin
                                if (!cur_bit) begin
                                    n_hdr = 4'd2; n_char = hufd_pkg::PFX_2B;
                                    n_bits_left = 5'd13; n_phase = hufd_pkg::PH_CBITS;
                                end else begin
                                    n_hdr = 4'd3;
                                end
                            end
                            default: begin
                                n_phase = hufd_pkg::PH_CBITS;
                                if (!cur_bit) begin
                                    n_hdr = 4'd3; n_char = hufd_pkg::PFX_3B;
                                    n_bits_left = 5'd20;
                                end else begin
                                    n_hdr = 4'd4; n_char = hufd_pkg::PFX_4B;
                                    n_bits_left = 5'd28;
                                end
                            end
                        endcase
                    end
                    hufd_pkg::PH_CBITS: begin
                        if (r_bits_left == 5'd0 || r_bits_left > 5'd28) begin
                            n_err = 1'b1; n_phase = hufd_pkg::PH_STOP;
                        end else begin
                            n_bits_left = nb;
                            n_char      = nchar;
                            if (nb == 5'd0) begin
                                if (!hufd_pkg::char_ok(nchar, r_hdr)) begin
                                    n_err = 1'b1; n_phase = hufd_pkg::PH_STOP;
                                end else begin
                                    tree_we    = 1'b1;
                                    tree_waddr = node_dec[AW-1:0];
                                    tree_wdata = {1'b1, 2'(r_hdr - 4'd1), nchar};
                                    if (r_stk_cnt == '0) begin
                                        if (r_node_cnt == CW'(1)) begin
                                            n_err = 1'b1; n_phase = hufd_pkg::PH_STOP;
                                        end else begin
                                            n_phase     = hufd_pkg::PH_CHDR;
                                            n_cur       = '0;
                                            n_cur_right = r_root_right;
                                        end
                                    end else begin
                                        n_stk_cnt = r_stk_cnt - SCW'(1);
                                        adv       = 1'b0;
                                        n_state   = hufd_pkg::ST_POP;
                                    end
                                end
                            end
                        end
                    end
                    hufd_pkg::PH_CHDR: begin
                        if (cur_bit) begin
                            n_chunk = KW'(hufd_pkg::FULL_CHUNK);
                            n_last_chunk = 1'b0;
                            n_phase = hufd_pkg::PH_SYM;
                        end else begin
                            n_chunk = '0; n_last_chunk = 1'b1; n_hdr = '0;
                            n_phase = hufd_pkg::PH_CCNT;
                        end
                    end
                    hufd_pkg::PH_CCNT: begin
                        n_chunk = {1'b0, r_chunk[10:0], cur_bit};
                        n_hdr   = r_hdr + 4'd1;
                        if (n_hdr >= 4'd12) begin
                            if (n_chunk != '0) begin
                                n_phase = hufd_pkg::PH_SYM;
                            end else begin
                                n_phase = r_last_chunk ? hufd_pkg::PH_STOP : hufd_pkg::PH_CHDR;
                            end
                        end
                    end
                    hufd_pkg::PH_SYM: begin
                        if (sym_next[CW-1]) begin
                            n_err = 1'b1; n_phase = hufd_pkg::PH_STOP;
                        end else begin
                            n_next     = sym_next[AW-1:0];
                            tree_raddr = sym_next[AW-1:0];
                            adv        = 1'b0;
                            n_state    = hufd_pkg::ST_LOOK;
                        end
                    end
                    default: begin
                        n_phase = hufd_pkg::PH_STOP;
                    end
                endcase
            end
            hufd_pkg::ST_POP: begin
                tree_we    = 1'b1;
                tree_waddr = stk_rdata;
                tree_wdata = EW'(r_node_cnt);
                if (stk_rdata == '0) begin
                    n_root_right = r_node_cnt;
                end
                n_phase = hufd_pkg::PH_TREE;
                adv     = 1'b1;
            end
            hufd_pkg::ST_LOOK: begin
                if (!tree_rdata[EW-1]) begin
                    n_cur       = r_next;
                    n_cur_right = tree_rdata[CW-1:0];
                    adv         = 1'b1;
                end else begin
                    n_emit     = tree_rdata;
                    n_emit_cnt = tree_rdata[33:32];
                    n_state    = hufd_pkg::ST_EMIT;
                end
            end
            hufd_pkg::ST_EMIT: begin
                put_en   = 1'b1;
                put_byte = r_emit[8*r_emit_cnt +: 8];
                if (put_ok) begin
                    if (r_emit_cnt == 2'd0) begin
                        n_cur       = '0;
                        n_cur_right = r_root_right;
                        n_chunk     = chunk_dec;
                        if (chunk_dec != '0) begin
                            n_phase = hufd_pkg::PH_SYM;
                        end else begin
                            n_phase = r_last_chunk ? hufd_pkg::PH_STOP : hufd_pkg::PH_CHDR;
                        end
                        adv = 1'b1;
                    end else begin
                        n_emit_cnt = r_emit_cnt - 2'd1;
                    end
                end
            end
            hufd_pkg::ST_END: begin
                if (r_phase != hufd_pkg::PH_STOP && r_in_last) begin
                    n_err   = 1'b1;
                    n_phase = hufd_pkg::PH_STOP;
                    n_state = hufd_pkg::ST_STAT;
                end else if (r_phase == hufd_pkg::PH_STOP) begin
                    n_state = hufd_pkg::ST_STAT;
                end else begin
                    n_state = hufd_pkg::ST_FLUSH;
                end
            end
            hufd_pkg::ST_STAT: begin
                put_en   = 1'b1;
                put_user = {r_err, !r_err};
                if (put_ok) begin
                    n_state = hufd_pkg::ST_FLUSH;
                end
            end
            hufd_pkg::ST_FLUSH: begin
                if (!r_hold_v) begin
                    n_state = hufd_pkg::ST_IDLE;
                end else if (out_free) begin
                    n_out_v    = 1'b1;
                    n_out_byte = r_hold_byte;
                    n_out_user = r_hold_user;
                    n_out_last = 1'b1;
                    n_hold_v   = 1'b0;
                    n_state    = hufd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = hufd_pkg::ST_IDLE;
            end
        endcase

        if (put_en && put_ok) begin
            if (r_hold_v) begin
                n_out_v    = 1'b1;
                n_out_byte = r_hold_byte;
                n_out_user = r_hold_user;
                n_out_last = 1'b0;
            end
            n_hold_v    = 1'b1;
            n_hold_byte = put_byte;
            n_hold_user = put_user;
        end

        if (adv) begin
            if (n_phase == hufd_pkg::PH_STOP || r_bit == 3'd0) begin
                n_state = hufd_pkg::ST_END;
            end else begin
                n_bit   = r_bit - 3'd1;
                n_state = hufd_pkg::ST_BIT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= hufd_pkg::ST_IDLE;
            r_phase      <= hufd_pkg::PH_TREE;
            r_char       <= '0;
            r_bits_left  <= '0;
            r_hdr        <= '0;
            r_node_cnt   <= '0;
            r_stk_cnt    <= '0;
            r_cur        <= '0;
            r_cur_right  <= '0;
            r_root_right <= '0;
            r_chunk      <= '0;
            r_last_chunk <= 1'b0;
            r_err        <= 1'b0;
            r_hold_v     <= 1'b0;
            r_out_v      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_phase      <= n_phase;
            r_char       <= n_char;
            r_bits_left  <= n_bits_left;
            r_hdr        <= n_hdr;
            r_node_cnt   <= n_node_cnt;
            r_stk_cnt    <= n_stk_cnt;
            r_cur        <= n_cur;
            r_cur_right  <= n_cur_right;
            r_root_right <= n_root_right;
            r_chunk      <= n_chunk;
            r_last_chunk <= n_last_chunk;
            r_err        <= n_err;
            r_hold_v     <= n_hold_v;
            r_out_v      <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte      <= n_byte;
        r_in_last   <= n_in_last;
        r_bit       <= n_bit;
        r_next      <= n_next;
        r_emit      <= n_emit;
        r_emit_cnt  <= n_emit_cnt;
        r_hold_byte <= n_hold_byte;
        r_hold_user <= n_hold_user;
        r_out_byte  <= n_out_byte;
        r_out_last  <= n_out_last;
        r_out_user  <= n_out_user;
    end

    a_idle_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == hufd_pkg::ST_IDLE |-> !r_hold_v)
        else $error("hold register still full while idle");

    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stk_cnt <= SCW'(hufd_pkg::TREE_DEPTH))
        else $error("parse stack count out of range");

    a_err_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |-> r_phase == hufd_pkg::PH_STOP)
        else $error("error flagged without stop");

    a_node_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_node_cnt <= CW'(hufd_pkg::TREE_NODES))
        else $error("node count out of range");

endmodule

// ===== design/hufd_ram.sv =====
// Generic simple dual-port RAM with registered read.
module hufd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== test/tb.sv =====
// Testbench for the Huffman UTF-8 stream decoder: random streams checked against a bit-level predictor.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_in_word;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       done;
        logic       err;
    } t_out_word;

    typedef struct {
        logic [63:0] code;
        int          len;
    } t_leaf_code;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'd0;
    logic       s_axis_tlast = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;
    logic [1:0] m_axis_tuser;   // out_done, out_error

    huffman_utf8_stream_decoder dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .m_axis_tuser(m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_in_word   pend_q[$];
    t_out_word  decoded_q[$];
    bit         code_bits[$];
    t_leaf_code leaf_codes[$];
    int         errors = 0;
    int         cycles = 0;
    int         chars_made = 0;

    // decoder model state
    logic [34:0]      nodes [hufd_pkg::TREE_NODES];
    logic [9:0]       pstack [hufd_pkg::TREE_DEPTH];
    int unsigned      sdepth = 0;
    hufd_pkg::t_phase ph = hufd_pkg::PH_TREE;
    logic [31:0]      cshift = 0;
    int unsigned      nbits = 0;
    int unsigned      ncount = 0;
    int unsigned      cur = 0;
    int unsigned      cleft = 0;
    int unsigned      hbits = 0;
    logic             lastc = 1'b0;
    logic             errf = 1'b0;

    function automatic bit cont_ok(logic [7:0] c);
        return c[7:6] == 2'b10;
    endfunction

    function automatic bit utf8_valid(logic [31:0] v, int unsigned sz);
        case (sz)
            1: return v[31:7] == 0;
            2: return v[31:16] == 0 && v[15:13] == 3'b110 && cont_ok(v[7:0]);
            3: return v[31:24] == 0 && v[23:20] == 4'b1110 && cont_ok(v[15:8])
                      && cont_ok(v[7:0]);
            default: begin
                if (v[31:27] != 5'b11110 || !cont_ok(v[23:16]) || !cont_ok(v[15:8])
                    || !cont_ok(v[7:0]))
                    return 0;
                if (v[31:24] > 8'd244 || (v[31:24] == 8'd244 && v[23:16] >= 8'd144))
                    return 0;
                return 1;
            end
        endcase
    endfunction

    function automatic void halt_error();
        errf = 1'b1;
        ph = hufd_pkg::PH_STOP;
    endfunction

    function automatic void end_of_symbol();
        if (cleft != 0) ph = hufd_pkg::PH_SYM;
        else if (lastc) ph = hufd_pkg::PH_STOP;
        else ph = hufd_pkg::PH_CHDR;
    endfunction

    function automatic void push_out(logic [7:0] d, logic dn, logic er);
        t_out_word w;
        w.data = d;
        w.last = 1'b0;
        w.done = dn;
        w.err = er;
        decoded_q.push_back(w);
    endfunction

    function automatic void begin_payload(int unsigned sz, logic [31:0] pfx, int unsigned nb);
        hbits = sz;
        cshift = pfx;
        nbits = nb;
        ph = hufd_pkg::PH_CBITS;
    endfunction

    function automatic void decode_bit(bit b);
        int unsigned idx, nxt, sz;
        logic [34:0] e;
        case (ph)
            hufd_pkg::PH_TREE: begin
                if (ncount >= hufd_pkg::TREE_NODES) begin
                    halt_error();
                    return;
                end
                idx = ncount;
                ncount++;
                if (b) begin
                    cshift = 0;
                    hbits = 0;
                    ph = hufd_pkg::PH_CSIZE;
                    return;
                end
                if (sdepth >= hufd_pkg::TREE_DEPTH) begin
                    halt_error();
                    return;
                end
                nodes[idx] = 35'd0;
                pstack[sdepth] = idx[9:0];
                sdepth++;
            end
            hufd_pkg::PH_CSIZE: begin
                if (hbits == 0) begin
                    if (!b) begin_payload(1, 32'd0, 7); else hbits = 1;
                end else if (hbits == 1) begin
                    if (!b) halt_error(); else hbits = 2;
                end else if (hbits == 2) begin
                    if (!b) begin_payload(2, 32'h0000_C000, 13); else hbits = 3;
                end else begin
                    if (!b) begin_payload(3, 32'h00E0_0000, 20);
                    else begin_payload(4, 32'hF000_0000, 28);
                end
            end
            hufd_pkg::PH_CBITS: begin
                if (nbits == 0 || nbits > 28) begin
                    halt_error();
                    return;
                end
                nbits--;
                cshift = cshift | (32'(b) << nbits);
                if (nbits == 0) begin
                    if (!utf8_valid(cshift, hbits)) begin
                        halt_error();
                        return;
                    end
                    nodes[(ncount - 1) % hufd_pkg::TREE_NODES] = {1'b1, 2'(hbits - 1), cshift};
                    if (sdepth == 0) begin
                        if (ncount == 1) begin
                            halt_error();
                            return;
                        end
                        ph = hufd_pkg::PH_CHDR;
                        cur = 0;
                        return;
                    end
                    sdepth--;
                    nodes[pstack[sdepth]] = nodes[pstack[sdepth]] | 35'(ncount);
                    ph = hufd_pkg::PH_TREE;
                end
            end
            hufd_pkg::PH_CHDR: begin
                if (b) begin
                    cleft = hufd_pkg::FULL_CHUNK;
                    lastc = 1'b0;
                    ph = hufd_pkg::PH_SYM;
                end else begin
                    cleft = 0;
                    lastc = 1'b1;
                    hbits = 0;
                    ph = hufd_pkg::PH_CCNT;
                end
            end
            hufd_pkg::PH_CCNT: begin
                cleft = ((cleft << 1) | b) & 32'hFFF;
                hbits++;
                if (hbits >= 12) end_of_symbol();
            end
            hufd_pkg::PH_SYM: begin
                e = nodes[cur % hufd_pkg::TREE_NODES];
                nxt = b ? e[31:0] : cur + 1;
                if (nxt >= hufd_pkg::TREE_NODES) begin
                    halt_error();
                    return;
                end
                e = nodes[nxt];
                if (!e[34]) begin
                    cur = nxt;
                    return;
                end
                sz = e[33:32] + 1;
                for (int k = sz; k > 0; k--)
                    push_out(8'(e[31:0] >> (8 * (k - 1))), 1'b0, 1'b0);
                cur = 0;
                cleft--;
                end_of_symbol();
            end
            default: ;
        endcase
    endfunction

    function automatic void decode_word(logic [7:0] d, logic l);
        int n0;
        n0 = decoded_q.size();
        if (ph == hufd_pkg::PH_STOP) return;
        for (int i = 7; i >= 0 && ph != hufd_pkg::PH_STOP; i--)
            decode_bit(d[i]);
        if (l && ph != hufd_pkg::PH_STOP) halt_error();
        if (ph == hufd_pkg::PH_STOP) push_out(8'd0, !errf, errf);
        if (decoded_q.size() > n0) decoded_q[decoded_q.size() - 1].last = 1'b1;
    endfunction

    // stream construction
    function automatic void push_field(logic [31:0] v, int n);
        for (int i = n - 1; i >= 0; i--)
            code_bits.push_back(v[i]);
    endfunction

    function automatic void push_leaf(logic [63:0] path, int plen);
        logic [31:0] v;
        int sz;
        t_leaf_code lc;
        logic [2:0] l4;
        lc.code = path;
        lc.len = plen;
        leaf_codes.push_back(lc);
        code_bits.push_back(1'b1);
        case (chars_made)
            0: begin sz = 1; v = 32'h00; end
            1: begin sz = 1; v = 32'h7F; end
            2: begin sz = 2; v = 32'hC280; end
            3: begin sz = 2; v = 32'hDFBF; end
            4: begin sz = 3; v = 32'hE0A080; end
            5: begin sz = 3; v = 32'hEFBFBF; end
            6: begin sz = 4; v = 32'hF0908080; end
            7: begin sz = 4; v = 32'hF48FBFBF; end
            default: begin
                sz = $urandom_range(1, 4);
                v = $urandom;
                case (sz)
                    1: v = v & 32'h7F;
                    2: v = 32'hC080 | (v & 32'h1F3F);
                    3: v = 32'hE08080 | (v & 32'h0F3F3F);
                    default: begin
                        l4 = 3'($urandom_range(0, 4));
                        v[31:24] = 8'hF0 | l4;
                        v[23:16] = (l4 == 4) ? (8'h80 | v[19:16]) : (8'h80 | v[21:16]);
                        v[15:8] = 8'h80 | v[13:8];
                        v[7:0] = 8'h80 | v[5:0];
                    end
                endcase
            end
        endcase
        chars_made++;
        case (sz)
            1: begin push_field(32'b0, 1); push_field(v, 7); end
            2: begin push_field(32'b110, 3); push_field(v, 13); end
            3: begin push_field(32'b1110, 4); push_field(v, 20); end
            default: begin push_field(32'b1111, 4); push_field(v, 28); end
        endcase
    endfunction

    function automatic void grow(int depth, logic [63:0] path, int plen);
        if (depth >= 7 || (depth > 1 && $urandom_range(0, 3) == 0)) begin
            push_leaf(path, plen);
        end else begin
            code_bits.push_back(1'b0);
            grow(depth + 1, path << 1, plen + 1);
            grow(depth + 1, (path << 1) | 64'd1, plen + 1);
        end
    endfunction

    function automatic void push_symbol(int k);
        for (int i = leaf_codes[k].len - 1; i >= 0; i--)
            code_bits.push_back(leaf_codes[k].code[i]);
    endfunction

    task automatic report(string what, logic [7:0] got, logic [7:0] want);
        $display("mismatch %s: got %h want %h (cycle %0d)", what, got, want, cycles);
        errors++;
    endtask

    // driver
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        t_in_word w;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                decode_word(s_axis_tdata, s_axis_tlast);
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (pend_q.size() > 0) begin
                    w = pend_q.pop_front();
                    s_axis_tdata <= w.data;
                    s_axis_tlast <= w.last;
                    s_axis_tvalid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_word w;
        cycles++;
        if (cycles > 600000) begin
            $display("huffman_utf8_stream_decoder test failed");
            $finish;
        end
        if (i_rst_n) begin
            if (cycles[10:9] == 2'b00) m_axis_tready <= 1'b1;
            else m_axis_tready <= $urandom_range(0, 3) != 0;
            if (m_axis_tvalid && m_axis_tready) begin
                if (decoded_q.size() == 0) begin
                    report("unexpected word", m_axis_tdata, 8'h00);
                end else begin
                    w = decoded_q.pop_front();
                    if (m_axis_tdata !== w.data) report("out_byte", m_axis_tdata, w.data);
                    if (m_axis_tlast !== w.last) report("out_last", 8'(m_axis_tlast), 8'(w.last));
                    if (m_axis_tuser[0] !== w.done)
                        report("out_done", 8'(m_axis_tuser[0]), 8'(w.done));
                    if (m_axis_tuser[1] !== w.err)
                        report("out_error", 8'(m_axis_tuser[1]), 8'(w.err));
                end
            end
        end
    end

    initial begin
        t_in_word w;
        int nsym, nbytes, cut, tree_bytes;
        bit early;
        code_bits.push_back(1'b0);
        grow(1, 64'd0, 1);
        grow(1, 64'd1, 1);
        tree_bytes = code_bits.size() / 8 + 1;
        code_bits.push_back(1'b0);
        nsym = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(100, 400);
        push_field(nsym, 12);
        for (int i = 0; i < nsym; i++)
            push_symbol($urandom_range(0, leaf_codes.size() - 1));
        while (code_bits.size() % 8 != 0)
            code_bits.push_back(1'($urandom_range(0, 1)));
        nbytes = code_bits.size() / 8;
        early = ($urandom_range(0, 3) == 0) && nbytes > tree_bytes + 2;
        cut = early ? $urandom_range(tree_bytes, nbytes - 2) : nbytes;
        for (int i = 0; i < cut; i++) begin
            for (int j = 0; j < 8; j++)
                w.data[7 - j] = code_bits[i * 8 + j];
            w.last = (i == cut - 1);
            pend_q.push_back(w);
        end
        for (int i = 0; i < 4; i++) begin
            w.data = 8'($urandom);
            w.last = 1'($urandom_range(0, 1));
            pend_q.push_back(w);
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (pend_q.size() > 0 || s_axis_tvalid) @(posedge i_clk);
        while (decoded_q.size() > 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (errors == 0) $display("huffman_utf8_stream_decoder test passed");
        else $display("huffman_utf8_stream_decoder test failed");
        $finish;
    end
endmodule
